@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/cshl_pkg.sv @@
`default_nettype none
package cshl_pkg;

  typedef enum logic [2:0] {
    CLS_NORMAL  = 3'd0,
    CLS_NUMBER  = 3'd1,
    CLS_STRING  = 3'd2,
    CLS_LINECMT = 3'd3,
    CLS_BLKCMT  = 3'd4,
    CLS_KW1     = 3'd5,
    CLS_KW2     = 3'd6
  } hl_class_e;

  localparam logic [1:0] REG_SYNTAX_ENABLE     = 2'd0;
  localparam logic [1:0] REG_HIGHLIGHT_NUMBERS = 2'd1;
  localparam logic [1:0] REG_HIGHLIGHT_STRINGS = 2'd2;

  localparam logic [1:0] QUOTE_NONE   = 2'd0;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
  localparam logic [1:0] QUOTE_SINGLE = 2'd2;

  typedef struct packed {
    logic       in_bc;
    logic [1:0] quote;
    logic       after_sep;
    hl_class_e  prev_cls;
    logic [3:0] run_left;
    hl_class_e  run_cls;
    logic       line_rest;
  } lex_state_t;

  localparam int KW_COUNT = 28;
  localparam int KW_MAXLEN = 8;

  // text right-justified: first character in the top used byte
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'("break"), 64'("else"), 64'("if"), 64'("continue"),
    64'("union"), 64'("typedef"), 64'("void"), 64'("switch"),
    64'("case"), 64'("default"), 64'("while"), 64'("return"),
    64'("class"), 64'("static"), 64'("for"), 64'("do"),
    64'("define"), 64'("int"), 64'("double"), 64'("float"),
    64'("char"), 64'("long"), 64'("unsigned"), 64'("signed"),
    64'("struct"), 64'("class"), 64'("enum"), 64'("bool")
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd4, 4'd2, 4'd8, 4'd5, 4'd7, 4'd4, 4'd6,
    4'd4, 4'd7, 4'd5, 4'd6, 4'd5, 4'd6, 4'd3, 4'd2,
    4'd6, 4'd3, 4'd6, 4'd5, 4'd4, 4'd4, 4'd8, 4'd6,
    4'd6, 4'd5, 4'd4, 4'd4
  };

  localparam hl_class_e KW_CLS [KW_COUNT] = '{
    CLS_KW1, CLS_KW1, CLS_KW1, CLS_KW1, CLS_KW1, CLS_KW1, CLS_KW2, CLS_KW1,
    CLS_KW1, CLS_KW1, CLS_KW1, CLS_KW1, CLS_KW1, CLS_KW1, CLS_KW1, CLS_KW1,
    CLS_KW1, CLS_KW2, CLS_KW2, CLS_KW2, CLS_KW2, CLS_KW2, CLS_KW2, CLS_KW2,
    CLS_KW2, CLS_KW2, CLS_KW2, CLS_KW2
  };

  function automatic logic is_sep(input logic [7:0] c);
    logic s;
    s = (c == 8'd0) || (c == 8'd32) || (c >= 8'd9 && c <= 8'd13) ||
        (c == ",") || (c == ".") || (c == "(") || (c == ")") ||
        (c == "+") || (c == "-") || (c == "/") || (c == "*") ||
        (c == "=") || (c == "~") || (c == "%") || (c == "<") ||
        (c == ">") || (c == "[") || (c == "]") || (c == ";");
    return s;
  endfunction

  function automatic lex_state_t row_clear(input lex_state_t s);
    lex_state_t r;
    r = s;
    r.quote     = QUOTE_NONE;
    r.after_sep = 1'b1;
    r.prev_cls  = CLS_NORMAL;
    r.run_left  = 4'd0;
    r.run_cls   = CLS_NORMAL;
    r.line_rest = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/cshl_if.sv @@
`default_nettype none
interface cshl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last_in_row;
  logic       start_of_file;
  modport source (output valid, ch, last_in_row, start_of_file, input ready);
  modport sink (input valid, ch, last_in_row, start_of_file, output ready);
endinterface

interface cshl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] hl_class;
  logic       last_of_row;
  logic       comment_open;
  modport source (output valid, hl_class, last_of_row, comment_open, input ready);
  modport sink (input valid, hl_class, last_of_row, comment_open, output ready);
endinterface

interface cshl_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic       wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

@@ rtl/c_syntax_highlight_classifier_core.sv @@
`default_nettype none
// C syntax highlighting classifier. Takes one character beat per cycle when
// not stalled and returns one class beat per character, in order, LOOKAHEAD
// characters late; the window of LOOKAHEAD+1 characters feeds parallel
// keyword and delimiter compares, so an unstalled row streams at one
// character per cycle. When the row's last character is taken the pending
// classes (up to LOOKAHEAD+1) drain via the single result register at one
// beat per unstalled cycle; input waits. Config writes are always accepted.
module c_syntax_highlight_classifier_core #(
  parameter int LOOKAHEAD = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  cshl_in_if.sink         in_i,
  cshl_out_if.source      out_o,
  cshl_cfg_if.sink        cfg_i
);
  `include "assert_macros.svh"

  localparam int W  = LOOKAHEAD + 1;
  localparam int CW = $clog2(W + 1);
  localparam int IW = $clog2(W);
  localparam logic [CW-1:0] WCNT = CW'(W);
  localparam int KW_HITS_W = cshl_pkg::KW_COUNT;

  logic [7:0] win_q [W];
  logic [7:0] win_d [W];
  logic [7:0] wv [W];
  logic [7:0] wm [W];
  logic [CW-1:0] cnt_q, cnt_d, cnt_b, cnt_v;
  logic flush_q, flush_d;
  cshl_pkg::lex_state_t st_q, st_d, st_v, st_n;
  logic en_q, num_q, str_q;

  logic out_valid_q, out_valid_d;
  cshl_pkg::hl_class_e cls_q, cls_n;
  logic last_q, copen_q;

  logic can_out, in_acc, pop, fin;
  logic [7:0] c, n;
  logic [KW_HITS_W-1:0] kw_hit;
  logic kw_any;
  logic [3:0] kw_len;
  cshl_pkg::hl_class_e kw_cls;

  assign can_out = !out_valid_q || out_o.ready;
  assign in_i.ready = !flush_q && can_out;
  assign in_acc = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // working view: pushed window on an input beat, held window otherwise
  always_comb begin
    cshl_pkg::lex_state_t sb;
    sb = st_q;
    cnt_b = cnt_q;
    if (in_acc && in_i.start_of_file) begin
      sb = cshl_pkg::row_clear(st_q);
      sb.in_bc = 1'b0;
      cnt_b = '0;
    end
    for (int k = 0; k < W; k++) wv[k] = win_q[k];
    if (in_acc) begin
      wv[cnt_b[IW-1:0]] = in_i.ch;
      cnt_v = cnt_b + CW'(1);
      st_v = sb;
    end else begin
      cnt_v = cnt_q;
      st_v = st_q;
    end
    for (int k = 0; k < W; k++) wm[k] = (CW'(k) < cnt_v) ? wv[k] : 8'd0;
  end

  assign c = wm[0];
  assign n = wm[1];

  // keyword compares, all in parallel; first entry in table order wins
  always_comb begin
    for (int k = 0; k < cshl_pkg::KW_COUNT; k++) begin
      logic h;
      h = 1'b1;
      for (int j = 0; j < cshl_pkg::KW_MAXLEN; j++) begin
        if (j < int'(cshl_pkg::KW_LEN[k]))
          h = h && (wm[j] ==
                    cshl_pkg::KW_TEXT[k][8*(int'(cshl_pkg::KW_LEN[k])-1-j) +: 8]);
      end
      kw_hit[k] = h && cshl_pkg::is_sep(wm[cshl_pkg::KW_LEN[k]]);
    end
    kw_any = |kw_hit;
    kw_len = 4'd1;
    kw_cls = cshl_pkg::CLS_NORMAL;
    for (int k = cshl_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (kw_hit[k]) begin
        kw_len = cshl_pkg::KW_LEN[k];
        kw_cls = cshl_pkg::KW_CLS[k];
      end
    end
  end

  // classify the head character
  always_comb begin
    logic dig, bc_open;
    st_n = st_v;
    cls_n = cshl_pkg::CLS_NORMAL;
    dig = (c >= "0") && (c <= "9");
    bc_open = (st_v.quote == cshl_pkg::QUOTE_NONE);
    if (!en_q) begin
      cls_n = cshl_pkg::CLS_NORMAL;
    end else if (st_v.run_left != 4'd0) begin
      st_n.run_left = st_v.run_left - 4'd1;
      cls_n = st_v.run_cls;
    end else if (st_v.line_rest) begin
      cls_n = cshl_pkg::CLS_LINECMT;
    end else if (bc_open && !st_v.in_bc && c == "/" && n == "/") begin
      st_n.line_rest = 1'b1;
      cls_n = cshl_pkg::CLS_LINECMT;
    end else if (bc_open && st_v.in_bc) begin
      if (c == "*" && n == "/") begin
        st_n.run_left = 4'd1;
        st_n.run_cls = cshl_pkg::CLS_BLKCMT;
        st_n.after_sep = 1'b1;
        st_n.in_bc = 1'b0;
      end
      cls_n = cshl_pkg::CLS_BLKCMT;
    end else if (bc_open && c == "/" && n == "*") begin
      st_n.run_left = 4'd1;
      st_n.run_cls = cshl_pkg::CLS_BLKCMT;
      st_n.in_bc = 1'b1;
      cls_n = cshl_pkg::CLS_BLKCMT;
    end else if (str_q && !bc_open) begin
      if (c == 8'h5C && cnt_v >= CW'(2)) begin
        st_n.run_left = 4'd1;
        st_n.run_cls = cshl_pkg::CLS_STRING;
      end else begin
        if ((st_v.quote == cshl_pkg::QUOTE_DOUBLE && c == 8'h22) ||
            (st_v.quote == cshl_pkg::QUOTE_SINGLE && c == 8'h27))
          st_n.quote = cshl_pkg::QUOTE_NONE;
        st_n.after_sep = 1'b1;
      end
      cls_n = cshl_pkg::CLS_STRING;
    end else if (str_q && c == 8'h22) begin
      st_n.quote = cshl_pkg::QUOTE_DOUBLE;
      cls_n = cshl_pkg::CLS_STRING;
    end else if (str_q && c == 8'h27) begin
      st_n.quote = cshl_pkg::QUOTE_SINGLE;
      cls_n = cshl_pkg::CLS_STRING;
    end else if (num_q && ((dig && (st_v.after_sep || st_v.prev_cls == cshl_pkg::CLS_NUMBER))
                           || (c == "." && st_v.prev_cls == cshl_pkg::CLS_NUMBER))) begin
      st_n.after_sep = 1'b0;
      cls_n = cshl_pkg::CLS_NUMBER;
    end else if (st_v.after_sep && kw_any) begin
      st_n.run_left = kw_len - 4'd1;
      st_n.run_cls = kw_cls;
      st_n.after_sep = 1'b0;
      cls_n = kw_cls;
    end else begin
      st_n.after_sep = cshl_pkg::is_sep(c);
    end
    if (en_q) st_n.prev_cls = cls_n;
  end

  assign pop = (in_acc && !in_i.last_in_row && cnt_v == WCNT) || (flush_q && can_out);
  assign fin = flush_q && cnt_v == CW'(1);

  always_comb begin
    for (int k = 0; k < W; k++) win_d[k] = wv[k];
    cnt_d = cnt_v;
    st_d = st_v;
    flush_d = flush_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (in_acc && in_i.last_in_row) flush_d = 1'b1;
    if (pop) begin
      // advance the window by one
      for (int k = 0; k < W - 1; k++) win_d[k] = wv[k + 1];
      cnt_d = cnt_v - CW'(1);
      st_d = st_n;
      out_valid_d = 1'b1;
      if (fin) begin
        flush_d = 1'b0;
        st_d = cshl_pkg::row_clear(st_n);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      flush_q <= 1'b0;
      st_q <= cshl_pkg::row_clear('0);
      out_valid_q <= 1'b0;
      en_q <= 1'b1;
      num_q <= 1'b1;
      str_q <= 1'b1;
    end else begin
      cnt_q <= cnt_d;
      flush_q <= flush_d;
      st_q <= st_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          cshl_pkg::REG_SYNTAX_ENABLE:     en_q <= cfg_i.wdata;
          cshl_pkg::REG_HIGHLIGHT_NUMBERS: num_q <= cfg_i.wdata;
          cshl_pkg::REG_HIGHLIGHT_STRINGS: str_q <= cfg_i.wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < W; k++) win_q[k] <= win_d[k];
    if (pop) begin
      cls_q <= cls_n;
      last_q <= fin;
      copen_q <= fin && st_n.in_bc;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.hl_class = cls_q;
  assign out_o.last_of_row = last_q;
  assign out_o.comment_open = copen_q;

  `ASSERT_IMPL(a_no_input_while_draining, clk_i, rst_ni, flush_q, !in_i.ready)
  `ASSERT_IMPL(a_count_bound, clk_i, rst_ni, !flush_q, cnt_q < WCNT)
  `ASSERT_IMPL(a_open_only_at_row_end, clk_i, rst_ni,
               out_o.valid && !out_o.last_of_row, !out_o.comment_open)
  `ASSERT_NEXT(a_drain_ends_empty, clk_i, rst_ni, pop && fin, cnt_q == '0 && !flush_q)

endmodule
`default_nettype wire

@@ dv/c_syntax_highlight_classifier_core_tb.sv @@
`default_nettype none
module c_syntax_highlight_classifier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cshl_pkg::hl_class_e cls;
    logic                last;
    logic                copen;
  } class_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cshl_in_if  in_if ();
  cshl_out_if out_if ();
  cshl_cfg_if cfg_if ();

  c_syntax_highlight_classifier_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  // lexer mirror
  logic                syn_en, num_en, str_en;
  logic [7:0]          win [9];
  int                  pend;
  logic                in_bc;
  logic [1:0]          quote;
  logic                after_sep;
  cshl_pkg::hl_class_e prev_cls;
  int                  run_left;
  cshl_pkg::hl_class_e run_cls;
  logic                line_rest;

  class_beat_t exp_classes [$];
  int mismatches = 0;
  int chars_sent = 0;
  int classes_seen = 0;
  int rows_sent = 0;
  bit stall_out = 1'b1;

  function automatic logic [7:0] win_at(int k);
    return (k < pend && k < 9) ? win[k] : 8'd0;
  endfunction

  function automatic logic sep_char(logic [7:0] c);
    string seps;
    seps = ",.()+-/*=~%<>[];";
    if (c == 8'd0 || c == " " || (c >= 8'd9 && c <= 8'd13)) return 1'b1;
    for (int i = 0; i < seps.len(); i++) if (seps[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [7:0] kw_char(int k, int j);
    return cshl_pkg::KW_TEXT[k][8*(cshl_pkg::KW_LEN[k]-1-j) +: 8];
  endfunction

  function void clear_row();
    quote = cshl_pkg::QUOTE_NONE;
    after_sep = 1'b1;
    prev_cls = cshl_pkg::CLS_NORMAL;
    run_left = 0;
    run_cls = cshl_pkg::CLS_NORMAL;
    line_rest = 1'b0;
  endfunction

  function cshl_pkg::hl_class_e classify_head();
    logic [7:0] c, n;
    logic hit;
    c = win_at(0);
    n = win_at(1);
    if (!syn_en) return cshl_pkg::CLS_NORMAL;
    if (run_left != 0) begin
      run_left--;
      return run_cls;
    end
    if (line_rest) return cshl_pkg::CLS_LINECMT;
    if (quote == cshl_pkg::QUOTE_NONE && !in_bc && c == "/" && n == "/") begin
      line_rest = 1'b1;
      return cshl_pkg::CLS_LINECMT;
    end
    if (quote == cshl_pkg::QUOTE_NONE) begin
      if (in_bc) begin
        if (c == "*" && n == "/") begin
          run_left = 1; run_cls = cshl_pkg::CLS_BLKCMT; after_sep = 1'b1; in_bc = 1'b0;
        end
        return cshl_pkg::CLS_BLKCMT;
      end
      if (c == "/" && n == "*") begin
        run_left = 1; run_cls = cshl_pkg::CLS_BLKCMT; in_bc = 1'b1;
        return cshl_pkg::CLS_BLKCMT;
      end
    end
    if (str_en) begin
      if (quote != cshl_pkg::QUOTE_NONE) begin
        if (c == "\\" && pend >= 2) begin
          run_left = 1; run_cls = cshl_pkg::CLS_STRING;
          return cshl_pkg::CLS_STRING;
        end
        if ((quote == cshl_pkg::QUOTE_DOUBLE && c == "\"") ||
            (quote == cshl_pkg::QUOTE_SINGLE && c == "'"))
          quote = cshl_pkg::QUOTE_NONE;
        after_sep = 1'b1;
        return cshl_pkg::CLS_STRING;
      end
      if (c == "\"") begin quote = cshl_pkg::QUOTE_DOUBLE; return cshl_pkg::CLS_STRING; end
      if (c == "'") begin quote = cshl_pkg::QUOTE_SINGLE; return cshl_pkg::CLS_STRING; end
    end
    if (num_en) begin
      if ((c >= "0" && c <= "9" && (after_sep || prev_cls == cshl_pkg::CLS_NUMBER)) ||
          (c == "." && prev_cls == cshl_pkg::CLS_NUMBER)) begin
        after_sep = 1'b0;
        return cshl_pkg::CLS_NUMBER;
      end
    end
    if (after_sep) begin
      for (int k = 0; k < cshl_pkg::KW_COUNT; k++) begin
        hit = 1'b1;
        for (int j = 0; j < cshl_pkg::KW_LEN[k]; j++)
          if (win_at(j) != kw_char(k, j)) hit = 1'b0;
        if (hit && sep_char(win_at(cshl_pkg::KW_LEN[k]))) begin
          run_left = cshl_pkg::KW_LEN[k] - 1;
          run_cls = cshl_pkg::KW_CLS[k];
          after_sep = 1'b0;
          return cshl_pkg::KW_CLS[k];
        end
      end
    end
    after_sep = sep_char(c);
    return cshl_pkg::CLS_NORMAL;
  endfunction

  function void emit_class(logic fin);
    class_beat_t b;
    b.cls = classify_head();
    if (syn_en) prev_cls = b.cls;
    for (int i = 0; i < 8; i++) win[i] = win[i+1];
    if (pend > 0) pend--;
    b.last = fin;
    b.copen = fin ? in_bc : 1'b0;
    exp_classes.push_back(b);
  endfunction

  function void predict_char(logic [7:0] c, logic lst, logic sof);
    if (sof) begin
      pend = 0; in_bc = 1'b0; clear_row();
    end
    if (pend >= 9) pend = 8;
    win[pend] = c;
    pend++;
    if (lst) begin
      while (pend > 0) emit_class(pend == 1);
      clear_row();
    end else if (pend >= 9) emit_class(1'b0);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  bit idle_in = 1'b1;

  task automatic send_char(logic [7:0] c, logic lst, logic sof);
    int g;
    g = idle_in ? gap_len() : 0;
    @(negedge clk_i);
    if (g > 0) begin
      in_if.valid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.ch = c;
    in_if.last_in_row = lst;
    in_if.start_of_file = sof;
    do @(posedge clk_i); while (!in_if.ready);
    predict_char(c, lst, sof);
    chars_sent++;
    if (lst) rows_sent++;
  endtask

  task automatic send_row(string s, logic sof = 1'b0);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], i == s.len() - 1, sof && i == 0);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    wait (exp_classes.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic val);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.wdata = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      cshl_pkg::REG_SYNTAX_ENABLE:     syn_en = val;
      cshl_pkg::REG_HIGHLIGHT_NUMBERS: num_en = val;
      cshl_pkg::REG_HIGHLIGHT_STRINGS: str_en = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_modes(logic se, logic ne, logic st);
    settle();
    write_reg(cshl_pkg::REG_SYNTAX_ENABLE, se);
    write_reg(cshl_pkg::REG_HIGHLIGHT_NUMBERS, ne);
    write_reg(cshl_pkg::REG_HIGHLIGHT_STRINGS, st);
  endtask

  // result side: random back-pressure, check at the accepting edge
  always @(negedge clk_i) begin
    if (stall_out) out_if.ready <= (gap_len() == 0);
    else out_if.ready <= 1'b1;
  end

  always @(posedge clk_i) begin
    class_beat_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      classes_seen++;
      if (exp_classes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected class beat %0d", out_if.hl_class);
      end else begin
        e = exp_classes.pop_front();
        if (out_if.hl_class !== e.cls || out_if.last_of_row !== e.last ||
            out_if.comment_open !== e.copen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp cls %0d last %0b open %0b, got cls %0d last %0b open %0b",
                     e.cls, e.last, e.copen, out_if.hl_class, out_if.last_of_row,
                     out_if.comment_open);
        end
      end
    end
  end

  task automatic test_directed();
    send_row("int x=0;", 1'b1);
    send_row("if(a)//c");
    send_row("/* open");
    send_row("x */ y");
    send_row("\"a\\\"b\" 'c'");
    send_row("2.5 .3");
    send_row("\"ab\\");
    send_row("unsigned continue typedef default;");
    send_char(8'h00, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b0);
    send_char(8'h80, 1'b1, 1'b0);
    send_row("/* abc");
    send_char("x", 1'b0, 1'b0);
    send_char("y", 1'b0, 1'b0);
    send_row("do{", 1'b1);   // file restart mid row drops the pending pair
  endtask

  task automatic test_modes();
    for (int m = 0; m < 8; m++) begin
      set_modes(m[0], m[1], m[2]);
      send_row("'/*'4 do//");
    end
    set_modes(1'b1, 1'b1, 1'b1);
    send_row("\"s /*");
    set_modes(1'b1, 1'b1, 1'b0);   // the open quote was cleared at row end
    send_row("a /* */ y");
    set_modes(1'b0, 1'b1, 1'b1);
    send_row("/* k");              // comment flag held while disabled
    set_modes(1'b1, 1'b1, 1'b1);
    send_row("x */ z");
  endtask

  function automatic string rand_token();
    string toks [20];
    int kw;
    string s;
    toks = '{" ", "/*", "*/", "//", "\"", "'", "\\", "1", "42", "3.14",
             ".", "(", ";", "x", "ab", "\t", ",", "*", "/", "_"};
    case ($urandom_range(0, 5))
      0, 1: begin
        kw = $urandom_range(0, cshl_pkg::KW_COUNT - 1);
        s = "";
        for (int j = 0; j < cshl_pkg::KW_LEN[kw]; j++) s = {s, string'(kw_char(kw, j))};
        return s;
      end
      2: begin
        s = " ";
        s[0] = 8'($urandom_range(1, 255));
        return s;
      end
      default: return toks[$urandom_range(0, 19)];
    endcase
  endfunction

  task automatic test_random();
    string row;
    int ntok;
    int base;
    base = chars_sent;
    while (chars_sent - base < 30) begin
      if (chars_sent - base > 10 && chars_sent - base < 20) begin
        // hold the sender until every class has drained
        @(negedge clk_i);
        in_if.valid = 1'b0;
        wait (exp_classes.size() == 0);
      end
      idle_in = ($urandom_range(0, 3) != 0);
      stall_out = ($urandom_range(0, 3) != 0);
      row = "";
      ntok = $urandom_range(1, 6);
      for (int t = 0; t < ntok; t++) row = {row, rand_token()};
      if ($urandom_range(0, 9) == 0) begin
        // broken row: random bytes, file restart inside
        for (int i = 0; i < row.len(); i++) send_char(row[i], 1'b0, 1'b0);
        send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        send_char(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end else begin
        send_row(row, $urandom_range(0, 19) == 0);
      end
    end
    idle_in = 1'b1;
    stall_out = 1'b1;
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.ch = 8'd0;
    in_if.last_in_row = 1'b0;
    in_if.start_of_file = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = cshl_pkg::REG_SYNTAX_ENABLE;
    cfg_if.wdata = 1'b0;
    out_if.ready = 1'b0;
    syn_en = 1'b1; num_en = 1'b1; str_en = 1'b1;
    for (int i = 0; i < 9; i++) win[i] = 8'd0;
    pend = 0;
    in_bc = 1'b0;
    clear_row();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_modes();
    test_random();
    settle();
    $display("sent %0d characters in %0d rows, checked %0d class beats over 8 modes",
             chars_sent, rows_sent, classes_seen);
    if (mismatches == 0 && exp_classes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d classes outstanding", mismatches, exp_classes.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d classes outstanding", exp_classes.size());
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
